[hw/rtl/npe_pkg.sv]
// npe_pkg: shared types and constants of the rational b-spline point evaluator
// transaction payload structs, item kinds, register indexes, divider port structs, fsm states
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package npe_pkg;

    // item kinds
    localparam logic [1:0] KIND_POINT = 2'd0;
    localparam logic [1:0] KIND_KNOT  = 2'd1;
    localparam logic [1:0] KIND_EVAL  = 2'd2;

    // configuration register indexes
    localparam int CFG_AW = 2;
    localparam int CFG_DW = 7;
    localparam logic [CFG_AW-1:0] CFG_DEGREE = 2'd0;
    localparam logic [CFG_AW-1:0] CFG_POINTS = 2'd1;
    localparam logic [CFG_AW-1:0] CFG_DIM    = 2'd2;

    // coordinate fields carried on the ports
    localparam int OUT_DIM = 5;
    localparam int OUT_IW  = 3;

    // divider step counts and the width of the step field
    localparam int DIV_STEPS_W = 6;
    localparam logic [DIV_STEPS_W-1:0] ALPHA_STEPS = 6'd32;
    localparam logic [DIV_STEPS_W-1:0] POINT_STEPS = 6'd33;

    typedef struct packed {
        logic        [1:0]  kind;
        logic        [6:0]  index;
        logic signed [31:0] coord_0;
        logic signed [31:0] coord_1;
        logic signed [31:0] coord_2;
        logic signed [31:0] coord_3;
        logic signed [31:0] coord_4;
        logic        [31:0] weight;
        logic        [31:0] knot_value;
        logic        [31:0] param_u;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] point_0;
        logic signed [31:0] point_1;
        logic signed [31:0] point_2;
        logic signed [31:0] point_3;
        logic signed [31:0] point_4;
        logic               weight_error;
    } out_item_t;

    typedef struct packed {
        logic                   start;
        logic [31:0]            rem_init;
        logic [31:0]            divisor;
        logic [32:0]            low_bits;
        logic [DIV_STEPS_W-1:0] steps;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [32:0] quotient;
    } div_rsp_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_LO,
        ST_HI,
        ST_CLAMP,
        ST_SPAN,
        ST_BS_RD,
        ST_BS_CMP,
        ST_LD_RD,
        ST_LD_MUL,
        ST_LD_WR,
        ST_AK_RD,
        ST_AK_RD2,
        ST_AK_CHK,
        ST_AK_DIV,
        ST_BL_RD,
        ST_BL_SUB,
        ST_BL_ABS,
        ST_BL_MLO,
        ST_BL_MHI,
        ST_BL_SUM,
        ST_BL_WR,
        ST_FN_RD,
        ST_FN_W,
        ST_FN_CRD,
        ST_FN_ABS,
        ST_FN_ADD,
        ST_FN_CHK,
        ST_FN_DIV,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

[hw/rtl/npe_div.sv]
// npe_div: restoring divider, one quotient bit per cycle
// uses npe_pkg for the request and response structs
`timescale 1ns / 1ps
`default_nettype none

module npe_div (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire npe_pkg::div_req_t req,
    output npe_pkg::div_rsp_t      rsp
);

    logic                            run_reg, run_next;
    logic                            done_reg, done_next;
    logic [npe_pkg::DIV_STEPS_W-1:0] cnt_reg, cnt_next;
    logic [31:0]                     rem_reg, rem_next;
    logic [31:0]                     dvs_reg, dvs_next;
    logic [32:0]                     low_reg, low_next;
    logic [32:0]                     quo_reg, quo_next;
    logic [32:0]                     trial;
    logic                            ge;

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        low_next  = low_reg;
        quo_next  = quo_reg;
        trial     = {rem_reg, low_reg[32]};
        ge        = trial >= {1'b0, dvs_reg};
        if (req.start)
        begin
            run_next = 1'b1;
            cnt_next = req.steps;
            rem_next = req.rem_init;
            dvs_next = req.divisor;
            low_next = req.low_bits;
            quo_next = '0;
        end
        else if (run_reg)
        begin
            rem_next = ge ? 32'(trial - {1'b0, dvs_reg}) : trial[31:0];
            quo_next = {quo_reg[31:0], ge};
            low_next = {low_reg[31:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == npe_pkg::DIV_STEPS_W'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        low_reg <= low_next;
        quo_reg <= quo_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

`default_nettype wire

[hw/rtl/nurbs_point_evaluator.sv]
// nurbs_point_evaluator: top level of the rational b-spline curve point evaluator
// depends on npe_pkg and npe_div
`timescale 1ns / 1ps
`default_nettype none

// A transaction is taken when start is high and busy is low. Point and knot loads are
// written into their memories at that edge and give no result. An evaluate transaction
// keeps busy high until its result is shown: done is high for exactly one cycle with the
// point on result, and the receiver cannot stall it, so capture it then. The running time
// of an evaluate is set by the single shared bit-serial divider (alpha and the final
// projection, each started only where a divide is really needed), the one multiplier and
// the one write port of the working memory, visited once per homogeneous coordinate.
// Registers (degree, point_count, dimension) are written over cfg_we/cfg_addr/cfg_wdata;
// the user must write them only while the block is idle: the block does not enforce it.
// Memories have no reset: entries must be written first.

module nurbs_point_evaluator #(
    parameter int MAX_POINTS = 64,
    parameter int MAX_DEGREE = 3,
    parameter int MAX_DIM    = 5
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire npe_pkg::in_item_t              item,
    input  wire logic                           cfg_we,
    input  wire logic [npe_pkg::CFG_AW-1:0]     cfg_addr,
    input  wire logic [npe_pkg::CFG_DW-1:0]     cfg_wdata,
    output logic                                done,
    output npe_pkg::out_item_t                  result
);

    localparam int KNOT_DEPTH = MAX_POINTS + MAX_DEGREE + 1;
    localparam int KW  = $clog2(KNOT_DEPTH);
    localparam int AW  = $clog2(MAX_POINTS);
    localparam int JW  = $clog2(MAX_DEGREE + 1);
    localparam int CW  = $clog2(MAX_DIM + 1);
    localparam int WAW = JW + CW;

    // configuration registers
    logic [1:0] cfg_degree_reg;
    logic [6:0] cfg_points_reg;
    logic [2:0] cfg_dim_reg;

    npe_pkg::state_t state_reg, state_next;

    // memories: point rows hold the coordinates with the weight on top
    logic [MAX_DIM:0][31:0] point_mem [MAX_POINTS];
    logic [31:0]            knot_mem  [KNOT_DEPTH];
    logic [63:0]            work_mem  [2**WAW];

    logic [MAX_DIM:0][31:0] point_q_reg;
    logic [31:0]            knot_q_reg;
    logic [63:0]            wa_q_reg;
    logic [63:0]            wb_q_reg;

    logic          accept;
    logic          pt_we;
    logic          kn_we;
    logic [AW-1:0] pt_addr;
    logic [KW-1:0] knot_addr;
    logic [WAW-1:0] wa_addr;
    logic [WAW-1:0] wb_addr;
    logic          work_we;
    logic [63:0]   work_wdata;
    logic [MAX_DIM:0][31:0] pt_wdata;

    // datapath state
    logic [31:0]   u_reg, u_next;
    logic [31:0]   lo_reg, lo_next;
    logic [31:0]   hi_reg, hi_next;
    logic [KW-1:0] p_reg, p_next;
    logic [KW-1:0] n_reg, n_next;
    logic [CW-1:0] dim_reg, dim_next;
    logic [KW-1:0] low_reg, low_next;
    logic [KW-1:0] high_reg, high_next;
    logic [KW-1:0] span_reg, span_next;
    logic [JW-1:0] j_reg, j_next;
    logic [JW-1:0] r_reg, r_next;
    logic [CW-1:0] c_reg, c_next;
    logic [31:0]   klo_reg, klo_next;
    logic [32:0]   alpha_reg, alpha_next;
    logic          cneg_reg, cneg_next;
    logic [63:0]   a_reg, a_next;
    logic [63:0]   b_reg, b_next;
    logic [63:0]   diff_reg, diff_next;
    logic          dneg_reg, dneg_next;
    logic [63:0]   dmag_reg, dmag_next;
    logic [63:0]   plo_reg, plo_next;
    logic [63:0]   inc_reg, inc_next;
    logic [63:0]   prod_reg, prod_next;
    logic [31:0]   mul_a, mul_b;
    logic [63:0]   wh_reg, wh_next;
    logic          hneg_reg, hneg_next;
    logic [63:0]   hmag_reg, hmag_next;
    logic [71:0]   numer_reg, numer_next;
    logic [npe_pkg::OUT_DIM-1:0][31:0] pts_reg, pts_next;
    logic          werr_reg, werr_next;

    npe_pkg::div_req_t div_req;
    npe_pkg::div_rsp_t div_rsp;

    npe_div u_div (
        .clk (clk),
        .rst_n (rst_n),
        .req (div_req),
        .rsp (div_rsp)
    );

    // saturate a rounded quotient to signed 32 bits
    function automatic logic [31:0] sat_point(input logic neg, input logic ovf,
                                              input logic [32:0] q);
        logic [31:0] v;
        if (neg)
        begin
            if (ovf || q > 33'h080000000)
                v = 32'h80000000;
            else
                v = 32'(0) - q[31:0];
        end
        else
        begin
            if (ovf || q > 33'h07FFFFFFF)
                v = 32'h7FFFFFFF;
            else
                v = q[31:0];
        end
        return v;
    endfunction

    assign busy   = (state_reg != npe_pkg::ST_IDLE);
    assign accept = start && !busy;
    assign pt_we  = accept && (item.kind == npe_pkg::KIND_POINT)
                    && (int'(item.index) < MAX_POINTS);
    assign kn_we  = accept && (item.kind == npe_pkg::KIND_KNOT)
                    && (int'(item.index) < KNOT_DEPTH);

    // point row from the load transaction, weight in the top slot
    always_comb
    begin
        logic [npe_pkg::OUT_DIM-1:0][31:0] coords;
        coords   = {item.coord_4, item.coord_3, item.coord_2, item.coord_1, item.coord_0};
        pt_wdata = '0;
        for (int k = 0; k < MAX_DIM; k++)
            pt_wdata[k] = coords[k];
        pt_wdata[MAX_DIM] = item.weight;
    end

    // working memory addressing: {j, c}
    assign wa_addr = {JW'(j_reg - JW'(1)), c_reg};
    assign wb_addr = {j_reg, c_reg};
    assign pt_addr = AW'(span_reg - p_reg + KW'(j_reg));

    always_ff @(posedge clk)
    begin
        if (pt_we)
            point_mem[AW'(item.index)] <= pt_wdata;
        point_q_reg <= point_mem[pt_addr];
    end

    always_ff @(posedge clk)
    begin
        if (kn_we)
            knot_mem[KW'(item.index)] <= item.knot_value;
        knot_q_reg <= knot_mem[knot_addr];
    end

    always_ff @(posedge clk)
    begin
        if (work_we)
            work_mem[wb_addr] <= work_wdata;
        wa_q_reg <= work_mem[wa_addr];
        wb_q_reg <= work_mem[wb_addr];
    end

    // sequencer: clamp, span search, load, de boor, projection
    always_comb
    begin
        int          deg_i;
        int          dim_i;
        int          np_i;
        logic [31:0] uc;
        logic [31:0] coord;
        logic [63:0] hom_mag;
        logic [63:0] hom;
        logic [31:0] num;
        logic [31:0] den;
        logic [KW:0] mid_sum;
        logic [KW-1:0] mid;
        logic [JW-1:0] pj;
        logic        ovf;

        state_next = state_reg;
        u_next     = u_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        p_next     = p_reg;
        n_next     = n_reg;
        dim_next   = dim_reg;
        low_next   = low_reg;
        high_next  = high_reg;
        span_next  = span_reg;
        j_next     = j_reg;
        r_next     = r_reg;
        c_next     = c_reg;
        klo_next   = klo_reg;
        alpha_next = alpha_reg;
        cneg_next  = cneg_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        diff_next  = diff_reg;
        dneg_next  = dneg_reg;
        dmag_next  = dmag_reg;
        plo_next   = plo_reg;
        inc_next   = inc_reg;
        wh_next    = wh_reg;
        hneg_next  = hneg_reg;
        hmag_next  = hmag_reg;
        numer_next = numer_reg;
        pts_next   = pts_reg;
        werr_next  = werr_reg;

        work_we    = 1'b0;
        work_wdata = '0;
        mul_a      = '0;
        mul_b      = '0;
        knot_addr  = '0;

        div_req.start    = 1'b0;
        div_req.rem_init = '0;
        div_req.divisor  = '0;
        div_req.low_bits = '0;
        div_req.steps    = npe_pkg::ALPHA_STEPS;

        pj      = JW'(p_reg);
        mid_sum = (KW + 1)'(low_reg) + (KW + 1)'(high_reg);
        mid     = mid_sum[KW:1];
        num     = u_reg - klo_reg;
        den     = knot_q_reg - klo_reg;
        coord   = point_q_reg[c_reg];
        hom_mag = {8'b0, prod_reg[63:8]};
        hom     = cneg_reg ? 64'(0) - hom_mag : hom_mag;
        ovf     = {25'b0, numer_reg[71:33]} >= wh_reg;

        // register clamping for an evaluate
        deg_i = int'(cfg_degree_reg);
        if (deg_i < 1)
            deg_i = 1;
        if (deg_i > MAX_DEGREE)
            deg_i = MAX_DEGREE;
        dim_i = int'(cfg_dim_reg);
        if (dim_i < 1)
            dim_i = 1;
        if (dim_i > MAX_DIM)
            dim_i = MAX_DIM;
        np_i = int'(cfg_points_reg);
        if (np_i > MAX_POINTS)
            np_i = MAX_POINTS;
        if (np_i < deg_i + 1)
            np_i = deg_i + 1;
        uc = (u_reg > knot_q_reg) ? knot_q_reg : u_reg;
        uc = (uc < lo_reg) ? lo_reg : uc;

        unique case (state_reg)
            npe_pkg::ST_IDLE:
            begin
                if (accept && item.kind == npe_pkg::KIND_EVAL)
                begin
                    u_next     = item.param_u;
                    p_next     = KW'(deg_i);
                    dim_next   = CW'(dim_i);
                    n_next     = KW'(np_i - 1);
                    pts_next   = '0;
                    werr_next  = 1'b0;
                    state_next = npe_pkg::ST_LO;
                end
            end
            npe_pkg::ST_LO:
            begin
                knot_addr  = p_reg;
                state_next = npe_pkg::ST_HI;
            end
            npe_pkg::ST_HI:
            begin
                lo_next    = knot_q_reg;
                knot_addr  = n_reg + KW'(1);
                state_next = npe_pkg::ST_CLAMP;
            end
            npe_pkg::ST_CLAMP:
            begin
                hi_next    = knot_q_reg;
                u_next     = uc;
                state_next = npe_pkg::ST_SPAN;
            end
            npe_pkg::ST_SPAN:
            begin
                j_next = '0;
                c_next = '0;
                if (u_reg >= hi_reg)
                begin
                    span_next  = n_reg;
                    state_next = npe_pkg::ST_LD_RD;
                end
                else if (u_reg <= lo_reg)
                begin
                    span_next  = p_reg;
                    state_next = npe_pkg::ST_LD_RD;
                end
                else
                begin
                    low_next   = p_reg;
                    high_next  = n_reg + KW'(1);
                    state_next = npe_pkg::ST_BS_RD;
                end
            end
            npe_pkg::ST_BS_RD:
            begin
                knot_addr = mid;
                if (high_reg - low_reg > KW'(1))
                    state_next = npe_pkg::ST_BS_CMP;
                else
                begin
                    span_next  = low_reg;
                    state_next = npe_pkg::ST_LD_RD;
                end
            end
            npe_pkg::ST_BS_CMP:
            begin
                if (u_reg < knot_q_reg)
                    high_next = mid;
                else
                    low_next = mid;
                state_next = npe_pkg::ST_BS_RD;
            end
            npe_pkg::ST_LD_RD:
            begin
                // row of point span-p+j arrives next cycle
                state_next = npe_pkg::ST_LD_MUL;
            end
            npe_pkg::ST_LD_MUL:
            begin
                cneg_next  = coord[31];
                mul_a      = coord[31] ? 32'(0) - coord : coord;
                mul_b      = point_q_reg[MAX_DIM];
                state_next = npe_pkg::ST_LD_WR;
            end
            npe_pkg::ST_LD_WR:
            begin
                work_we = 1'b1;
                if (c_reg == CW'(MAX_DIM))
                    work_wdata = {32'b0, point_q_reg[MAX_DIM]};
                else if (c_reg < dim_reg)
                    work_wdata = hom;
                else
                    work_wdata = '0;
                if (c_reg == CW'(MAX_DIM))
                begin
                    c_next = '0;
                    if (j_reg == pj)
                    begin
                        r_next     = JW'(1);
                        state_next = npe_pkg::ST_AK_RD;
                    end
                    else
                    begin
                        j_next     = j_reg + JW'(1);
                        state_next = npe_pkg::ST_LD_RD;
                    end
                end
                else
                begin
                    c_next     = c_reg + CW'(1);
                    state_next = npe_pkg::ST_LD_MUL;
                end
            end
            npe_pkg::ST_AK_RD:
            begin
                knot_addr  = span_reg - p_reg + KW'(j_reg);
                state_next = npe_pkg::ST_AK_RD2;
            end
            npe_pkg::ST_AK_RD2:
            begin
                klo_next   = knot_q_reg;
                knot_addr  = span_reg + KW'(j_reg) + KW'(1) - KW'(r_reg);
                state_next = npe_pkg::ST_AK_CHK;
            end
            npe_pkg::ST_AK_CHK:
            begin
                c_next           = '0;
                div_req.rem_init = num;
                div_req.divisor  = den;
                div_req.low_bits = '0;
                div_req.steps    = npe_pkg::ALPHA_STEPS;
                // zero-width span or u at or below the left knot: alpha zero
                if (knot_q_reg <= klo_reg || u_reg <= klo_reg)
                begin
                    alpha_next = '0;
                    state_next = npe_pkg::ST_BL_RD;
                end
                else if (num >= den)
                begin
                    alpha_next = 33'h100000000;
                    state_next = npe_pkg::ST_BL_RD;
                end
                else
                begin
                    div_req.start = 1'b1;
                    state_next    = npe_pkg::ST_AK_DIV;
                end
            end
            npe_pkg::ST_AK_DIV:
            begin
                if (div_rsp.done)
                begin
                    alpha_next = {1'b0, div_rsp.quotient[31:0]};
                    state_next = npe_pkg::ST_BL_RD;
                end
            end
            npe_pkg::ST_BL_RD:
            begin
                state_next = npe_pkg::ST_BL_SUB;
            end
            npe_pkg::ST_BL_SUB:
            begin
                a_next     = wa_q_reg;
                b_next     = wb_q_reg;
                diff_next  = wb_q_reg - wa_q_reg;
                state_next = npe_pkg::ST_BL_ABS;
            end
            npe_pkg::ST_BL_ABS:
            begin
                dneg_next  = diff_reg[63];
                dmag_next  = diff_reg[63] ? 64'(0) - diff_reg : diff_reg;
                state_next = npe_pkg::ST_BL_MLO;
            end
            npe_pkg::ST_BL_MLO:
            begin
                mul_a      = dmag_reg[31:0];
                mul_b      = alpha_reg[31:0];
                state_next = npe_pkg::ST_BL_MHI;
            end
            npe_pkg::ST_BL_MHI:
            begin
                plo_next   = prod_reg;
                mul_a      = dmag_reg[63:32];
                mul_b      = alpha_reg[31:0];
                state_next = npe_pkg::ST_BL_SUM;
            end
            npe_pkg::ST_BL_SUM:
            begin
                inc_next   = prod_reg + {32'b0, plo_reg[63:32]};
                state_next = npe_pkg::ST_BL_WR;
            end
            npe_pkg::ST_BL_WR:
            begin
                work_we = 1'b1;
                if (alpha_reg[32])
                    work_wdata = b_reg;
                else if (dneg_reg)
                    work_wdata = a_reg - inc_reg;
                else
                    work_wdata = a_reg + inc_reg;
                if (c_reg == CW'(MAX_DIM))
                begin
                    c_next = '0;
                    if (j_reg == r_reg)
                    begin
                        j_next = pj;
                        if (r_reg == pj)
                        begin
                            c_next     = CW'(MAX_DIM);
                            state_next = npe_pkg::ST_FN_RD;
                        end
                        else
                        begin
                            r_next     = r_reg + JW'(1);
                            state_next = npe_pkg::ST_AK_RD;
                        end
                    end
                    else
                    begin
                        j_next     = j_reg - JW'(1);
                        state_next = npe_pkg::ST_AK_RD;
                    end
                end
                else
                begin
                    c_next     = c_reg + CW'(1);
                    state_next = npe_pkg::ST_BL_RD;
                end
            end
            npe_pkg::ST_FN_RD:
            begin
                // homogeneous weight at {p, MAX_DIM} arrives next cycle
                state_next = npe_pkg::ST_FN_W;
            end
            npe_pkg::ST_FN_W:
            begin
                wh_next = wb_q_reg;
                c_next  = '0;
                if (wb_q_reg == '0 || wb_q_reg[63])
                begin
                    werr_next  = 1'b1;
                    state_next = npe_pkg::ST_DONE;
                end
                else
                    state_next = npe_pkg::ST_FN_CRD;
            end
            npe_pkg::ST_FN_CRD:
            begin
                // unused coordinates stay zero
                if (c_reg >= dim_reg)
                    state_next = npe_pkg::ST_DONE;
                else
                    state_next = npe_pkg::ST_FN_ABS;
            end
            npe_pkg::ST_FN_ABS:
            begin
                hneg_next  = wb_q_reg[63];
                hmag_next  = wb_q_reg[63] ? 64'(0) - wb_q_reg : wb_q_reg;
                state_next = npe_pkg::ST_FN_ADD;
            end
            npe_pkg::ST_FN_ADD:
            begin
                // round half away: add half the weight before dividing
                numer_next = {hmag_reg, 8'b0} + {9'b0, wh_reg[63:1]};
                state_next = npe_pkg::ST_FN_CHK;
            end
            npe_pkg::ST_FN_CHK:
            begin
                div_req.rem_init = numer_reg[64:33];
                div_req.divisor  = wh_reg[31:0];
                div_req.low_bits = numer_reg[32:0];
                div_req.steps    = npe_pkg::POINT_STEPS;
                if (ovf)
                begin
                    pts_next[npe_pkg::OUT_IW'(c_reg)] = sat_point(hneg_reg, 1'b1, '0);
                    c_next     = c_reg + CW'(1);
                    state_next = npe_pkg::ST_FN_CRD;
                end
                else
                begin
                    div_req.start = 1'b1;
                    state_next    = npe_pkg::ST_FN_DIV;
                end
            end
            npe_pkg::ST_FN_DIV:
            begin
                if (div_rsp.done)
                begin
                    pts_next[npe_pkg::OUT_IW'(c_reg)] =
                        sat_point(hneg_reg, 1'b0, div_rsp.quotient);
                    c_next     = c_reg + CW'(1);
                    state_next = npe_pkg::ST_FN_CRD;
                end
            end
            npe_pkg::ST_DONE:
            begin
                state_next = npe_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = npe_pkg::ST_IDLE;
            end
        endcase

        prod_next = 64'(mul_a) * 64'(mul_b);
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= npe_pkg::ST_IDLE;
            cfg_degree_reg <= 2'd1;
            cfg_points_reg <= 7'd2;
            cfg_dim_reg    <= 3'd3;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                unique case (cfg_addr)
                    npe_pkg::CFG_DEGREE: cfg_degree_reg <= cfg_wdata[1:0];
                    npe_pkg::CFG_POINTS: cfg_points_reg <= cfg_wdata;
                    npe_pkg::CFG_DIM:    cfg_dim_reg    <= cfg_wdata[2:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        u_reg     <= u_next;
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        p_reg     <= p_next;
        n_reg     <= n_next;
        dim_reg   <= dim_next;
        low_reg   <= low_next;
        high_reg  <= high_next;
        span_reg  <= span_next;
        j_reg     <= j_next;
        r_reg     <= r_next;
        c_reg     <= c_next;
        klo_reg   <= klo_next;
        alpha_reg <= alpha_next;
        cneg_reg  <= cneg_next;
        a_reg     <= a_next;
        b_reg     <= b_next;
        diff_reg  <= diff_next;
        dneg_reg  <= dneg_next;
        dmag_reg  <= dmag_next;
        plo_reg   <= plo_next;
        inc_reg   <= inc_next;
        prod_reg  <= prod_next;
        wh_reg    <= wh_next;
        hneg_reg  <= hneg_next;
        hmag_reg  <= hmag_next;
        numer_reg <= numer_next;
        pts_reg   <= pts_next;
        werr_reg  <= werr_next;
    end

    // result transaction: one cycle, marked by done
    assign done                = (state_reg == npe_pkg::ST_DONE);
    assign result.point_0      = pts_reg[0];
    assign result.point_1      = pts_reg[1];
    assign result.point_2      = pts_reg[2];
    assign result.point_3      = pts_reg[3];
    assign result.point_4      = pts_reg[4];
    assign result.weight_error = werr_reg;

endmodule

`default_nettype wire

[test/nurbs_point_evaluator_test.sv]
// nurbs_point_evaluator_test: self-checking testbench of the rational b-spline point evaluator
// loads curves, evaluates them at many parameters and checks every point against a predictor
// depends on npe_pkg and nurbs_point_evaluator
`timescale 1ns / 1ps

module nurbs_point_evaluator_test;
    import npe_pkg::*;

    localparam int NPTS    = 64;
    localparam int NDEG    = 3;
    localparam int NDIM    = 5;
    localparam int NKNOTS  = NPTS + NDEG + 1;
    localparam int SETTLE  = 1200;        // longer than the slowest evaluate
    localparam int LIMIT   = 6000000;
    localparam longint unsigned ONE_Q32 = 64'h1_0000_0000;

    typedef enum logic [1:0] {OP_ITEM, OP_CFG, OP_DRAIN} plan_op_e;

    typedef struct {
        plan_op_e            op;
        in_item_t            payload;
        logic [CFG_AW-1:0]   addr;
        logic [CFG_DW-1:0]   data;
    } plan_entry_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    in_item_t           item = '0;
    logic               cfg_we = 1'b0;
    logic [CFG_AW-1:0]  cfg_addr = '0;
    logic [CFG_DW-1:0]  cfg_wdata = '0;
    logic               done;
    out_item_t          result;

    nurbs_point_evaluator DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .item     (item),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_wdata(cfg_wdata),
        .done     (done),
        .result   (result)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // pending stimulus and expected points
    plan_entry_t plan[$];
    out_item_t   expected_points[$];
    int          error_count = 0;
    int          cycle_count = 0;

    // predictor copy of the curve stores and registers
    logic signed [31:0] model_pts[NPTS][NDIM];
    logic [31:0]        model_wts[NPTS];
    logic [31:0]        model_knots[NKNOTS];
    logic [1:0]         model_degree = 2'd1;
    logic [6:0]         model_count  = 7'd2;
    logic [2:0]         model_dim    = 3'd3;

    // generator side: register values as they will be, and the knots it loaded
    logic [1:0]  gen_degree = 2'd1;
    logic [6:0]  gen_count  = 7'd2;
    logic [2:0]  gen_dim    = 3'd3;
    logic [31:0] gen_knots[NKNOTS];

    // clamped degree / control point count as the block uses them
    function automatic void effective(input logic [1:0] deg, input logic [6:0] cnt,
                                      output int p, output int np);
        p  = (deg < 1) ? 1 : ((deg > NDEG) ? NDEG : deg);
        np = (cnt > NPTS) ? NPTS : cnt;
        if (np < p + 1)
            np = p + 1;
    endfunction

    // weighted coordinate, truncated toward zero
    function automatic longint hom_coord(input longint c, input logic [31:0] w);
        longint unsigned mag;
        longint unsigned prod;
        mag  = (c < 0) ? longint'(-c) : longint'(c);
        prod = (mag * {32'd0, w}) >> 8;
        return (c < 0) ? -longint'(prod) : longint'(prod);
    endfunction

    // unsigned q1.32 interpolation factor
    function automatic longint unsigned knot_ratio(input logic [31:0] u, input logic [31:0] klo,
                                                   input logic [31:0] khi);
        longint unsigned num;
        longint unsigned den;
        if (khi <= klo || u <= klo)
            return 0;
        num = {32'd0, u - klo};
        den = {32'd0, khi - klo};
        if (num >= den)
            return ONE_Q32;
        return (num << 32) / den;
    endfunction

    function automatic longint lerp_q32(input longint a, input longint b,
                                       input longint unsigned alpha);
        longint          diff;
        longint unsigned mag;
        longint unsigned inc;
        if (alpha >= ONE_Q32)
            return b;
        diff = b - a;
        mag  = (diff < 0) ? longint'(-diff) : longint'(diff);
        inc  = (mag >> 32) * alpha + (((mag & 64'hFFFF_FFFF) * alpha) >> 32);
        return (diff < 0) ? a - longint'(inc) : a + longint'(inc);
    endfunction

    // curve point at u from the predictor stores
    function automatic out_item_t curve_point(input logic [31:0] u_in);
        int              p, np, n, dim, span, lo_i, hi_i, mid, base;
        logic [31:0]     u;
        longint          pts[NDEG+1][NDIM+1];
        longint          wh, h, v;
        longint unsigned alpha, mag, q;
        logic [31:0]     w;
        logic [31:0]     coords[NDIM];
        out_item_t       res;
        effective(model_degree, model_count, p, np);
        n   = np - 1;
        dim = (model_dim < 1) ? 1 : ((model_dim > NDIM) ? NDIM : model_dim);
        u = u_in;
        if (u > model_knots[n+1])
            u = model_knots[n+1];
        if (u < model_knots[p])
            u = model_knots[p];
        // span: end cases first, then bisection
        if (u >= model_knots[n+1])
            span = n;
        else if (u <= model_knots[p])
            span = p;
        else
        begin
            lo_i = p;
            hi_i = n + 1;
            while (hi_i - lo_i > 1)
            begin
                mid = (lo_i + hi_i) / 2;
                if (u < model_knots[mid])
                    hi_i = mid;
                else
                    lo_i = mid;
            end
            span = lo_i;
        end
        base = span - p;
        for (int j = 0; j <= p; j++)
        begin
            w = model_wts[base + j];
            for (int c = 0; c < NDIM; c++)
                pts[j][c] = (c < dim) ? hom_coord(longint'(model_pts[base + j][c]), w) : 0;
            pts[j][NDIM] = longint'({32'd0, w});
        end
        // de boor on homogeneous points
        for (int r = 1; r <= p; r++)
            for (int j = p; j >= r; j--)
            begin
                alpha = knot_ratio(u, model_knots[base + j], model_knots[base + j + p + 1 - r]);
                for (int c = 0; c <= NDIM; c++)
                    pts[j][c] = lerp_q32(pts[j-1][c], pts[j][c], alpha);
            end
        wh = pts[p][NDIM];
        for (int c = 0; c < NDIM; c++)
            coords[c] = '0;
        res = '0;
        if (wh <= 0)
        begin
            res.weight_error = 1'b1;
            return res;
        end
        for (int c = 0; c < dim; c++)
        begin
            h   = pts[p][c];
            mag = (h < 0) ? longint'(-h) : longint'(h);
            q   = ((mag << 8) + (longint'(wh) >> 1)) / longint'(wh);
            if (h < 0)
                v = (q > 64'h8000_0000) ? -64'sh8000_0000 : -longint'(q);
            else
                v = (q > 64'h7FFF_FFFF) ? 64'sh7FFF_FFFF : longint'(q);
            coords[c] = v[31:0];
        end
        res.point_0 = coords[0];
        res.point_1 = coords[1];
        res.point_2 = coords[2];
        res.point_3 = coords[3];
        res.point_4 = coords[4];
        return res;
    endfunction

    // update the predictor for one accepted transaction
    function automatic void apply_transaction(input in_item_t it);
        case (it.kind)
            KIND_POINT:
                if (it.index < NPTS)
                begin
                    model_pts[it.index][0] = it.coord_0;
                    model_pts[it.index][1] = it.coord_1;
                    model_pts[it.index][2] = it.coord_2;
                    model_pts[it.index][3] = it.coord_3;
                    model_pts[it.index][4] = it.coord_4;
                    model_wts[it.index]    = it.weight;
                end
            KIND_KNOT:
                if (it.index < NKNOTS)
                    model_knots[it.index] = it.knot_value;
            KIND_EVAL:
                expected_points.push_back(curve_point(it.param_u));
            default: ;  // unknown kind is dropped
        endcase
    endfunction

    // ---------------------------------------------------------------- stimulus building

    function automatic in_item_t random_payload();
        in_item_t it;
        it.kind       = 2'($urandom_range(3));
        it.index      = 7'($urandom_range(67));
        it.coord_0    = $urandom;
        it.coord_1    = $urandom;
        it.coord_2    = $urandom;
        it.coord_3    = $urandom;
        it.coord_4    = $urandom;
        it.weight     = $urandom;
        it.knot_value = $urandom;
        it.param_u    = $urandom;
        return it;
    endfunction

    function automatic logic [31:0] pick_coord(input int style);
        case ($urandom_range(9))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'(int'($urandom_range(200)) - 100) << 16;
            default: return (style == 0) ? $urandom : 32'($signed($urandom) >>> 8);
        endcase
    endfunction

    function automatic logic [31:0] pick_weight();
        case ($urandom_range(7))
            0:       return 32'd1;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h0100_0000;
            3:       return $urandom_range(32'h0400_0000, 32'h0040_0000);
            default: return ($urandom == 0) ? 32'd1 : $urandom | 32'd1;
        endcase
    endfunction

    task automatic push_transaction(input in_item_t it);
        plan_entry_t e;
        e.op      = OP_ITEM;
        e.payload = it;
        e.addr    = '0;
        e.data    = '0;
        plan.push_back(e);
    endtask

    task automatic push_drain();
        plan_entry_t e;
        e.op      = OP_DRAIN;
        e.payload = '0;
        e.addr    = '0;
        e.data    = '0;
        plan.push_back(e);
    endtask

    task automatic push_register(input logic [CFG_AW-1:0] addr, input logic [CFG_DW-1:0] data);
        plan_entry_t e;
        e.op      = OP_CFG;
        e.payload = '0;
        e.addr    = addr;
        e.data    = data;
        plan.push_back(e);
    endtask

    task automatic push_point(input int idx, input int style);
        in_item_t it;
        it         = random_payload();
        it.kind    = KIND_POINT;
        it.index   = 7'(idx);
        it.coord_0 = pick_coord(style);
        it.coord_1 = pick_coord(style);
        it.coord_2 = pick_coord(style);
        it.coord_3 = pick_coord(style);
        it.coord_4 = pick_coord(style);
        it.weight  = pick_weight();
        push_transaction(it);
    endtask

    task automatic push_knot(input int idx, input logic [31:0] value);
        in_item_t it;
        it            = random_payload();
        it.kind       = KIND_KNOT;
        it.index      = 7'(idx);
        it.knot_value = value;
        gen_knots[idx] = value;
        push_transaction(it);
    endtask

    task automatic push_eval(input logic [31:0] u);
        in_item_t it;
        it         = random_payload();
        it.kind    = KIND_EVAL;
        it.param_u = u;
        push_transaction(it);
    endtask

    // loads every point and knot that an evaluate can reach under the pending registers
    // knot shapes: 0 clamped sorted with repeats, 1 unsorted, 2 sorted open, 3 all equal
    task automatic load_curve(input int shape, input int coord_style);
        int          p, np, last;
        logic [31:0] k, step_max;
        effective(gen_degree, gen_count, p, np);
        last = np + p;
        for (int i = 0; i < np; i++)
            push_point(i, coord_style);
        step_max = 32'hFFFF_FFFF / (np + 2);
        k = (shape == 2) ? $urandom_range(32'h0010_0000) : 32'($urandom_range(3)) << 16;
        for (int i = 0; i <= last; i++)
        begin
            case (shape)
                0:
                    if (i > p && i < np + 1)
                        k = k + (($urandom_range(4) == 0) ? 32'd0 : $urandom_range(step_max, 1));
                    else if (i == np + 1)
                        k = k + $urandom_range(step_max, 1);
                1:
                    k = $urandom;
                2:
                    k = k + (($urandom_range(5) == 0) ? 32'd0 : $urandom_range(step_max));
                default: ;
            endcase
            push_knot(i, k);
        end
    endtask

    function automatic logic [31:0] pick_param();
        int          p, np, ki;
        logic [31:0] lo, hi;
        effective(gen_degree, gen_count, p, np);
        lo = gen_knots[p];
        hi = gen_knots[np];
        ki = $urandom_range(np + p);
        case ($urandom_range(9))
            0:       return $urandom;
            1:       return ($urandom_range(1)) ? 32'd0 : 32'hFFFF_FFFF;
            2:       return gen_knots[ki];
            3:       return gen_knots[ki] + 32'd1;
            4:       return gen_knots[ki] - 32'd1;
            default: return (hi > lo) ? $urandom_range(hi, lo) : $urandom;
        endcase
    endfunction

    // one register setting: idle, write all three registers, load, then evaluate
    task automatic run_setting(input logic [1:0] deg, input logic [6:0] cnt, input logic [2:0] dim,
                               input int evals);
        int p, np, pick;
        gen_degree = deg;
        gen_count  = cnt;
        gen_dim    = dim;
        push_drain();
        push_register(CFG_DEGREE, 7'(deg));
        push_register(CFG_POINTS, cnt);
        push_register(CFG_DIM, 7'(dim));
        effective(deg, cnt, p, np);
        load_curve(($urandom_range(5) < 3) ? 0 : $urandom_range(3), $urandom_range(1));
        for (int e = 0; e < evals; e++)
        begin
            pick = $urandom_range(19);
            if (e == evals / 2)
                push_drain();   // sender waits for every outstanding point
            if (pick == 0)
            begin
                in_item_t it;
                it      = random_payload();
                it.kind = 2'd3;
                push_transaction(it);
            end
            else if (pick == 1)
            begin
                in_item_t it;
                it       = random_payload();
                it.kind  = KIND_POINT;
                it.index = 7'($urandom_range(67, NPTS));   // dropped by the block
                push_transaction(it);
            end
            else if (pick == 2)
                push_point($urandom_range(np - 1), 0);
            else if (pick == 3)
                push_knot($urandom_range(np + p), $urandom);
            push_eval(pick_param());
        end
    endtask

    task automatic build_plan();
        // directed: reset registers (degree 1, two points, three coordinates)
        gen_degree = 2'd1;
        gen_count  = 7'd2;
        gen_dim    = 3'd3;
        begin
            in_item_t it;
            it = random_payload();
            it.kind = KIND_POINT; it.index = 7'd0;
            it.coord_0 = 32'h8000_0000; it.coord_1 = 32'h7FFF_FFFF; it.coord_2 = 32'h0;
            it.coord_3 = 32'hFFFF_FFFF; it.coord_4 = 32'h0001_0000; it.weight = 32'hFFFF_FFFF;
            push_transaction(it);
            it = random_payload();
            it.kind = KIND_POINT; it.index = 7'd1;
            it.coord_0 = 32'h7FFF_FFFF; it.coord_1 = 32'h8000_0000; it.coord_2 = 32'h0001_0000;
            it.coord_3 = 32'h0; it.coord_4 = 32'h8000_0000; it.weight = 32'd1;
            push_transaction(it);
            it = random_payload();
            it.kind = KIND_POINT; it.index = 7'd67;        // out of range, ignored
            push_transaction(it);
            it = random_payload();
            it.kind = 2'd3;                              // unknown kind, no result
            push_transaction(it);
        end
        push_knot(0, 32'd0);
        push_knot(1, 32'd0);
        push_knot(2, 32'hFFFF_FFFF);
        push_knot(3, 32'hFFFF_FFFF);
        push_knot(67, 32'h1234_5678);
        push_eval(32'd0);
        push_eval(32'hFFFF_FFFF);
        push_eval(32'h8000_0000);
        push_eval(32'd1);
        push_eval(32'hFFFF_FFFE);
        // zero-width domain: knots 1 and 2 equal
        push_knot(1, 32'h0005_0000);
        push_knot(2, 32'h0005_0000);
        push_eval(32'd0);
        push_eval(32'hFFFF_FFFF);

        // directed settings, extremes and out-of-range register values
        run_setting(2'd3, 7'd64, 3'd5, 40);
        run_setting(2'd1, 7'd2,  3'd1, 30);
        run_setting(2'd0, 7'd0,  3'd0, 25);     // clamps to degree 1, two points, one coord
        run_setting(2'd3, 7'd127, 3'd7, 30);    // clamps to 64 points, five coords
        run_setting(2'd3, 7'd1,  3'd6, 30);     // point count below degree plus one
        run_setting(2'd2, 7'd5,  3'd4, 30);

        // random settings, mostly small curves
        for (int s = 0; s < 10; s++)
            run_setting(2'($urandom_range(3)),
                        ($urandom_range(7) == 0) ? 7'($urandom_range(127)) : 7'($urandom_range(12)),
                        3'($urandom_range(7)), 90);
    endtask

    // ---------------------------------------------------------------- driver

    int  gap_cycles = 0;
    int  quiet_cycles = 0;

    always @(posedge clk or negedge rst_n)
    begin
        logic next_start;
        logic next_we;
        logic calm;
        if (!rst_n)
        begin
            start        <= 1'b0;
            cfg_we       <= 1'b0;
            gap_cycles   = 0;
            quiet_cycles = 0;
        end
        else
        begin
            next_start = start;
            next_we    = 1'b0;
            calm       = plan.size() < 150;    // no idling near the end
            // transaction taken at this edge
            if (start && !busy)
            begin
                apply_transaction(item);
                next_start = 1'b0;
                if (!calm && $urandom_range(3) == 0)
                    gap_cycles = $urandom_range(9, 1);
            end
            if (expected_points.size() == 0 && !start && !busy)
                quiet_cycles++;
            else
                quiet_cycles = 0;
            if (!next_start)
            begin
                if (gap_cycles > 0)
                    gap_cycles--;
                else if (plan.size() > 0)
                begin
                    case (plan[0].op)
                        OP_ITEM:
                        begin
                            item       <= plan[0].payload;
                            next_start = 1'b1;
                            void'(plan.pop_front());
                        end
                        OP_CFG:
                            if (quiet_cycles >= SETTLE)
                            begin
                                cfg_addr  <= plan[0].addr;
                                cfg_wdata <= plan[0].data;
                                next_we   = 1'b1;
                                case (plan[0].addr)
                                    CFG_DEGREE: model_degree = plan[0].data[1:0];
                                    CFG_POINTS: model_count  = plan[0].data;
                                    CFG_DIM:    model_dim    = plan[0].data[2:0];
                                    default: ;
                                endcase
                                void'(plan.pop_front());
                            end
                        default:
                            if (quiet_cycles >= SETTLE)
                                void'(plan.pop_front());
                    endcase
                end
            end
            start  <= next_start;
            cfg_we <= next_we;
        end
    end

    // ---------------------------------------------------------------- monitor

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch at %0t: %s got %h expected %h", $realtime, field, got, want);
        error_count++;
    endtask

    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && done)
        begin
            if (expected_points.size() == 0)
            begin
                $display("unexpected result at %0t", $realtime);
                error_count++;
            end
            else
            begin
                want = expected_points.pop_front();
                if (result.point_0 !== want.point_0)
                    report_mismatch("point_0", result.point_0, want.point_0);
                if (result.point_1 !== want.point_1)
                    report_mismatch("point_1", result.point_1, want.point_1);
                if (result.point_2 !== want.point_2)
                    report_mismatch("point_2", result.point_2, want.point_2);
                if (result.point_3 !== want.point_3)
                    report_mismatch("point_3", result.point_3, want.point_3);
                if (result.point_4 !== want.point_4)
                    report_mismatch("point_4", result.point_4, want.point_4);
                if (result.weight_error !== want.weight_error)
                    report_mismatch("weight_error", 32'(result.weight_error),
                                    32'(want.weight_error));
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        build_plan();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        wait (plan.size() == 0 && !start && expected_points.size() == 0);
        repeat (SETTLE) @(posedge clk);
        if (error_count == 0 && expected_points.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
